FILE: src/lmlt_pkg.sv
// ----------------------------------------------------------------------------
// lmlt_pkg
// Shared types, timing constants and helpers for the LCD mode/line timer.
// ----------------------------------------------------------------------------
package lmlt_pkg;

    // Mode lengths in machine cycles and line limits
    localparam int unsigned HBLANK_CYCLES      = 204;
    localparam int unsigned VBLANK_LINE_CYCLES = 456;
    localparam int unsigned OAM_CYCLES         = 80;
    localparam int unsigned TRANSFER_CYCLES    = 172;
    localparam int unsigned VISIBLE_LINES      = 144;
    localparam int unsigned LAST_LINE          = 153;

    // Field widths
    localparam int unsigned ELAPSED_W = 6;
    localparam int unsigned ACCUM_W   = 10;
    localparam int unsigned LINE_W    = 8;

    // APB register map
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [1:0] {
        REG_LCD_ENABLE  = 2'd0,
        REG_COMPARE     = 2'd1,
        REG_COINC_IRQEN = 2'd2,
        REG_UNUSED      = 2'd3
    } lmlt_reg_t;

    typedef enum logic [1:0] {
        LCD_HBLANK   = 2'd0,
        LCD_VBLANK   = 2'd1,
        LCD_OAM_SCAN = 2'd2,
        LCD_XFER     = 2'd3
    } lcd_mode_t;

    // Timer state carried between requests
    typedef struct packed {
        lcd_mode_t           mode;
        logic [ACCUM_W-1:0]  accum;
        logic [LINE_W-1:0]   line;
        logic                coinc;
    } lmlt_state_t;

    // Configuration seen by the step logic
    typedef struct packed {
        logic               lcd_enable;
        logic [LINE_W-1:0]  compare_line;
        logic               coinc_irq_enable;
    } lmlt_cfg_t;

    // Per-request event pulses
    typedef struct packed {
        logic vblank_irq;
        logic lcd_irq;
        logic render_line;
    } lmlt_pulse_t;

    // Length of the given mode in machine cycles
    function automatic logic [ACCUM_W-1:0] mode_length(lcd_mode_t m);
        logic [ACCUM_W-1:0] len;
        case (m)
            LCD_HBLANK:   len = ACCUM_W'(HBLANK_CYCLES);
            LCD_VBLANK:   len = ACCUM_W'(VBLANK_LINE_CYCLES);
            LCD_OAM_SCAN: len = ACCUM_W'(OAM_CYCLES);
            default:      len = ACCUM_W'(TRANSFER_CYCLES);
        endcase
        return len;
    endfunction

endpackage

FILE: src/lmlt_step.sv
// ----------------------------------------------------------------------------
// lmlt_step
// Next-state logic for one tick: when enabled, accumulate cycles, advance the
// mode at most once, step the line and run the coincidence check.
// ----------------------------------------------------------------------------
module lmlt_step
    import lmlt_pkg::*;
(
    input  lmlt_state_t           cur,
    input  lmlt_cfg_t             cfg,
    input  logic [ELAPSED_W-1:0]  elapsed_cycles,
    output lmlt_state_t           nxt,
    output lmlt_pulse_t           pulse
);

    logic [ACCUM_W-1:0] limit;
    logic [ACCUM_W-1:0] sum;
    logic [LINE_W-1:0]  line_inc;
    logic               do_compare;
    logic [LINE_W-1:0]  cmp_line;

    assign limit    = mode_length(cur.mode);
    assign sum      = cur.accum + ACCUM_W'(elapsed_cycles);
    assign line_inc = cur.line + LINE_W'(1);

    // Mode advance
    always_comb begin
        nxt        = cur;
        pulse      = '0;
        do_compare = 1'b0;
        cmp_line   = cur.line;
        if (cfg.lcd_enable) begin
            nxt.accum = sum;
            if (sum >= limit) begin
                nxt.accum = sum - limit;
                unique case (cur.mode)
                    LCD_HBLANK: begin
                        nxt.line   = line_inc;
                        do_compare = 1'b1;
                        if (line_inc < LINE_W'(VISIBLE_LINES)) begin
                            nxt.mode = LCD_OAM_SCAN;
                        end else begin
                            nxt.mode         = LCD_VBLANK;
                            pulse.vblank_irq = 1'b1;
                        end
                    end
                    LCD_VBLANK: begin
                        do_compare = 1'b1;
                        if (cur.line >= LINE_W'(LAST_LINE)) begin
                            nxt.line = '0;
                            nxt.mode = LCD_OAM_SCAN;
                        end else begin
                            nxt.line = line_inc;
                        end
                    end
                    LCD_OAM_SCAN: begin
                        nxt.mode = LCD_XFER;
                    end
                    LCD_XFER: begin
                        nxt.mode          = LCD_HBLANK;
                        pulse.render_line = 1'b1;
                    end
                    default: begin
                        nxt.mode = cur.mode;
                    end
                endcase
            end
            cmp_line = nxt.line;
        end
        // Coincidence check on line change only
        if (do_compare) begin
            nxt.coinc     = (cmp_line == cfg.compare_line);
            pulse.lcd_irq = (cmp_line == cfg.compare_line) && cfg.coinc_irq_enable;
        end
    end

endmodule

FILE: src/lcd_mode_line_timing.sv
// ----------------------------------------------------------------------------
// lcd_mode_line_timing
// Scanline mode and line sequencer driven by elapsed-cycle ticks.
// ----------------------------------------------------------------------------
// One tick request is taken per clock when not stalled. Its result appears
// on the m_ channel in the cycle after acceptance, from a single output
// register fed by the add/compare/mode-advance logic; s_ready stays high
// while that register is empty or being drained, so ticks stream at one per
// cycle under no backpressure. Configuration (enable, compare line,
// coincidence interrupt enable) is written over APB at byte addresses 0, 4 and 8.
module lcd_mode_line_timing
    import lmlt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ELAPSED_W-1:0] s_elapsed_cycles,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_mode,
    output logic [LINE_W-1:0]    m_line,
    output logic                 m_coincidence,
    output logic                 m_vblank_irq,
    output logic                 m_lcd_irq,
    output logic                 m_render_line,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    lmlt_cfg_t   cfg_reg;
    lmlt_state_t state_reg;
    lmlt_state_t state_next;
    lmlt_pulse_t pulse_next;
    lmlt_pulse_t pulse_reg;
    logic        m_valid_reg;
    logic        accept;
    logic        cfg_write;
    lmlt_reg_t   reg_sel;

    assign pready    = 1'b1;
    assign reg_sel   = lmlt_reg_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lcd_enable       <= 1'b1;
            cfg_reg.compare_line     <= '0;
            cfg_reg.coinc_irq_enable <= 1'b0;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_LCD_ENABLE:  cfg_reg.lcd_enable       <= pwdata[0];
                REG_COMPARE:     cfg_reg.compare_line     <= pwdata[LINE_W-1:0];
                REG_COINC_IRQEN: cfg_reg.coinc_irq_enable <= pwdata[0];
                default:         ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_LCD_ENABLE:  prdata[0]          = cfg_reg.lcd_enable;
            REG_COMPARE:     prdata[LINE_W-1:0] = cfg_reg.compare_line;
            REG_COINC_IRQEN: prdata[0]          = cfg_reg.coinc_irq_enable;
            default:         prdata             = '0;
        endcase
    end

    // Handshake: take a request whenever the output slot frees up
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    lmlt_step u_step (
        .cur            (state_reg),
        .cfg            (cfg_reg),
        .elapsed_cycles (s_elapsed_cycles),
        .nxt            (state_next),
        .pulse          (pulse_next)
    );

    // Timer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode  <= LCD_OAM_SCAN;
            state_reg.accum <= '0;
            state_reg.line  <= '0;
            state_reg.coinc <= 1'b0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    // Output pulses (payload, no reset)
    always_ff @(posedge aclk) begin
        if (accept) begin
            pulse_reg <= pulse_next;
        end
    end

    // Result fields mirror the updated state
    assign m_valid       = m_valid_reg;
    assign m_mode        = state_reg.mode;
    assign m_line        = state_reg.line;
    assign m_coincidence = state_reg.coinc;
    assign m_vblank_irq  = pulse_reg.vblank_irq;
    assign m_lcd_irq     = pulse_reg.lcd_irq;
    assign m_render_line = pulse_reg.render_line;

endmodule

FILE: src/lmlt_checker.sv
// ----------------------------------------------------------------------------
// lmlt_checker
// Port-level checks for the LCD mode/line timer, bound to the top level.
// ----------------------------------------------------------------------------
module lmlt_checker
    import lmlt_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [1:0]        m_mode,
    input logic [LINE_W-1:0] m_line,
    input logic              m_coincidence,
    input logic              m_vblank_irq,
    input logic              m_lcd_irq,
    input logic              m_render_line
);

    // VBlank interrupt only on entry into VBlank
    a_vblank_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_vblank_irq |-> m_mode == LCD_VBLANK)
        else $error("vblank_irq without VBlank mode");

    // Render pulse only when transfer has just handed over to HBlank
    a_render_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_render_line |-> m_mode == LCD_HBLANK && !m_vblank_irq)
        else $error("render_line outside HBlank entry");

    // LCD interrupt implies a match was just seen
    a_lcd_irq_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_lcd_irq |-> m_coincidence && !m_render_line)
        else $error("lcd_irq without coincidence");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mode) && $stable(m_line))
        else $error("result changed while stalled");

endmodule

bind lcd_mode_line_timing lmlt_checker u_lmlt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_mode        (m_mode),
    .m_line        (m_line),
    .m_coincidence (m_coincidence),
    .m_vblank_irq  (m_vblank_irq),
    .m_lcd_irq     (m_lcd_irq),
    .m_render_line (m_render_line)
);

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lcd_mode_line_timing. Tick requests go in over the
// s_ channel and results come back on m_ with random idling on both sides.
// A mode/line predictor tracks the timer, and every returned result is
// compared field by field. Configuration goes in over APB between phases.
// ----------------------------------------------------------------------------
module tb;
    import lmlt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RESET_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PHASE_TICKS  = 260;
    localparam int unsigned MAX_REPORTS  = 40;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_profile_t;

    // Expected outcome of one tick
    typedef struct packed {
        lcd_mode_t          mode;
        logic [LINE_W-1:0]  line;
        logic               coincidence;
        logic               vblank_irq;
        logic               lcd_irq;
        logic               render_line;
    } tick_result_t;

    // Predicts the timer and checks returned results in order
    class lcd_timing_scoreboard;
        lcd_mode_t          mode;
        logic [ACCUM_W-1:0] accum;
        logic [LINE_W-1:0]  line;
        logic               coinc;
        logic               enable;
        logic [LINE_W-1:0]  compare;
        logic               irq_enable;
        tick_result_t       expected_q[$];
        int                 errors;
        int                 checked;

        function new();
            mode       = LCD_OAM_SCAN;
            accum      = '0;
            line       = '0;
            coinc      = 1'b0;
            enable     = 1'b1;
            compare    = '0;
            irq_enable = 1'b0;
            errors     = 0;
            checked    = 0;
        endfunction

        function void set_reg(lmlt_reg_t r, logic [DATA_W-1:0] v);
            case (r)
                REG_LCD_ENABLE:  enable = v[0];
                REG_COMPARE:     compare = v[LINE_W-1:0];
                REG_COINC_IRQEN: irq_enable = v[0];
                default: ;
            endcase
        endfunction

        function int unsigned cycles_in(lcd_mode_t m);
            case (m)
                LCD_HBLANK:   return HBLANK_CYCLES;
                LCD_VBLANK:   return VBLANK_LINE_CYCLES;
                LCD_OAM_SCAN: return OAM_CYCLES;
                default:      return TRANSFER_CYCLES;
            endcase
        endfunction

        // Line compare on every line change; returns the interrupt request
        function logic line_compare();
            coinc = (line == compare);
            return coinc & irq_enable;
        endfunction

        function void note_tick(logic [ELAPSED_W-1:0] elapsed);
            tick_result_t r;
            int unsigned  len;
            r = '0;
            if (enable) begin
                len   = cycles_in(mode);
                accum = accum + ACCUM_W'(elapsed);
                if (accum >= ACCUM_W'(len)) begin
                    accum = accum - ACCUM_W'(len);
                    case (mode)
                        LCD_HBLANK: begin
                            line = line + LINE_W'(1);
                            if (line < LINE_W'(VISIBLE_LINES)) begin
                                mode = LCD_OAM_SCAN;
                            end else begin
                                mode = LCD_VBLANK;
                                r.vblank_irq = 1'b1;
                            end
                            r.lcd_irq = line_compare();
                        end
                        LCD_VBLANK: begin
                            if (line >= LINE_W'(LAST_LINE)) begin
                                line = '0;
                                mode = LCD_OAM_SCAN;
                            end else begin
                                line = line + LINE_W'(1);
                            end
                            r.lcd_irq = line_compare();
                        end
                        LCD_OAM_SCAN: mode = LCD_XFER;
                        default: begin
                            r.render_line = 1'b1;
                            mode = LCD_HBLANK;
                        end
                    endcase
                end
            end
            r.mode        = mode;
            r.line        = line;
            r.coincidence = coinc;
            expected_q.push_back(r);
        endfunction

        task report(string what, int got, int want);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch: %s on result %0d, got %0d, expected %0d",
                         what, checked, got, want);
        endtask

        task check(tick_result_t got);
            tick_result_t want;
            if (expected_q.size() == 0) begin
                report("unexpected result", 1, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.mode != want.mode)
                report("mode", got.mode, want.mode);
            if (got.line != want.line)
                report("line", got.line, want.line);
            if (got.coincidence != want.coincidence)
                report("coincidence", got.coincidence, want.coincidence);
            if (got.vblank_irq != want.vblank_irq)
                report("vblank_irq", got.vblank_irq, want.vblank_irq);
            if (got.lcd_irq != want.lcd_irq)
                report("lcd_irq", got.lcd_irq, want.lcd_irq);
            if (got.render_line != want.render_line)
                report("render_line", got.render_line, want.render_line);
            checked++;
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [ELAPSED_W-1:0] s_elapsed_cycles = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [1:0]           m_mode;
    logic [LINE_W-1:0]    m_line;
    logic                 m_coincidence;
    logic                 m_vblank_irq;
    logic                 m_lcd_irq;
    logic                 m_render_line;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    lcd_timing_scoreboard sb = new();

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;

    lcd_mode_line_timing i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_elapsed_cycles (s_elapsed_cycles),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_mode           (m_mode),
        .m_line           (m_line),
        .m_coincidence    (m_coincidence),
        .m_vblank_irq     (m_vblank_irq),
        .m_lcd_irq        (m_lcd_irq),
        .m_render_line    (m_render_line),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: long hold-off on request, otherwise random stalls
    always @(posedge aclk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check('{mode: lcd_mode_t'(m_mode), line: m_line,
                       coincidence: m_coincidence, vblank_irq: m_vblank_irq,
                       lcd_irq: m_lcd_irq, render_line: m_render_line});
    end

    task automatic set_idling(idle_profile_t p);
        case (p)
            IDLE_NONE:     begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_gap_pct = 76; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct = 76; end
            default:       begin send_gap_pct = 24; recv_stall_pct = 24; end
        endcase
    endtask

    // APB write: setup then access; register takes the value at the access edge
    task automatic reg_write(lmlt_reg_t r, logic [DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(r) << 2;
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(r, v);
        // Bus returns to idle before the next transfer
        @(posedge aclk);
    endtask

    // Offer one tick request and hold it until accepted
    task automatic send_tick(logic [ELAPSED_W-1:0] elapsed);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_elapsed_cycles <= elapsed;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(elapsed);
    endtask

    // Stop sending and let every expected result come back
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Mostly large ticks so the run gets through a whole frame
    function automatic logic [ELAPSED_W-1:0] pick_elapsed();
        if ($urandom_range(99) < 80)
            return ELAPSED_W'($urandom_range(63, 56));
        return ELAPSED_W'($urandom_range(63, 0));
    endfunction

    // Run limit
    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main sequence
    initial begin
        logic [ELAPSED_W-1:0] directed[] = '{6'd0, 6'd63, 6'd42, 6'd21};
        logic [LINE_W-1:0]    cmp_plan[] = '{8'd0, 8'd255, 8'd153, 8'd144, 8'd2, 8'd0};
        logic                 irq_plan[] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: bit extremes, then run to line 1 with a match armed
        set_idling(IDLE_NONE);
        reg_write(REG_COMPARE, 32'd1);
        reg_write(REG_COINC_IRQEN, 32'd1);
        foreach (directed[i])
            send_tick(directed[i]);
        repeat (12) send_tick(6'd63);
        drain();

        // Directed: LCD off holds state and clears the pulses
        reg_write(REG_LCD_ENABLE, 32'd0);
        send_tick(6'd0);
        send_tick(6'd63);
        send_tick(6'd33);
        drain();
        reg_write(REG_LCD_ENABLE, 32'd1);

        // Random phases with varying compare line and idling
        for (int p = 0; p < 6; p++) begin
            if (p == 5)
                reg_write(REG_COMPARE, DATA_W'($urandom_range(153)));
            else
                reg_write(REG_COMPARE, DATA_W'(cmp_plan[p]));
            reg_write(REG_COINC_IRQEN, DATA_W'(irq_plan[p]));
            set_idling(idle_profile_t'(p % 4));

            // Block fills up behind a long result hold-off
            if (p == 2)
                hold_reqs <= hold_reqs + 1;

            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (p == 1 && n == PHASE_TICKS / 2)
                    drain();
                send_tick(pick_elapsed());
            end
            drain();

            // Short stretch with the LCD off
            if (p == 3) begin
                reg_write(REG_LCD_ENABLE, 32'd0);
                repeat (30) send_tick(ELAPSED_W'($urandom_range(63)));
                drain();
                reg_write(REG_LCD_ENABLE, 32'd1);
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report("results still missing", 0, sb.pending());

        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
src/lmlt_pkg.sv
src/lmlt_step.sv
src/lcd_mode_line_timing.sv
src/lmlt_checker.sv
sim/tb.sv
